### rtl/core/least_squares_line_fit_macros.svh
// Assertion macros shared by the line-fit checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef LEAST_SQUARES_LINE_FIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define LSLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LSLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/lslf_pkg.sv
// Shared types and codes for the least-squares line fit block.
// No dependencies.
`timescale 1ns / 1ps

package lslf_pkg;

  typedef enum logic [2:0] {
    K_ADD    = 3'd0,
    K_REMOVE = 3'd1,
    K_FIND   = 3'd2,
    K_PRED_X = 3'd3,
    K_PRED_Y = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_REMOVED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FOUND      = 3'd4,
    ST_PREDICTED  = 3'd5,
    ST_DEGENERATE = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_RESP
  } state_e;

  // Multiply steps of the sequencer
  typedef enum logic [3:0] {
    M_XY,
    M_XX,
    M_NTXY,
    M_TXTY,
    M_NTXX,
    M_TXTX,
    M_NG,
    M_P5,
    M_P6,
    M_P7
  } step_e;

  typedef struct packed {
    logic start;
    logic find_free;
    logic commit_add;
    logic commit_remove;
  } store_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } store_rsp_t;

endpackage

### rtl/core/lslf_store.sv
// Point store: one synchronous memory of (x, y) pairs plus per-slot valid flops.
// Scans for the lowest free slot or the lowest exact match. Uses lslf_pkg.
`timescale 1ns / 1ps

module lslf_store #(
  parameter int MAX_POINTS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lslf_pkg::store_req_t  req_i,
  input  logic [15:0]           x_i,
  input  logic [15:0]           y_i,
  output lslf_pkg::store_rsp_t  rsp_o
);

  localparam int IW = $clog2(MAX_POINTS);

  logic [31:0]   mem [MAX_POINTS];
  logic          valid_q [MAX_POINTS];

  logic          issuing_q;
  logic [IW-1:0] issue_q;
  logic          cmp_q;
  logic [IW-1:0] cmp_idx_q;
  logic [31:0]   rd_data_q;
  logic          rd_vbit_q;
  logic          free_mode_q;

  logic match;
  logic last;
  logic stop;

  assign match = free_mode_q ? !rd_vbit_q : (rd_vbit_q && rd_data_q == {x_i, y_i});
  assign last  = cmp_idx_q == IW'(MAX_POINTS - 1);
  assign stop  = cmp_q && (match || last);

  assign rsp_o.done = stop;
  assign rsp_o.hit  = cmp_q && match;

  // commits arrive in the hit cycle, while cmp_idx_q still holds the matching slot
  always_ff @(posedge clk_i) begin
    if (issuing_q) begin
      rd_data_q <= mem[issue_q];
    end
    if (req_i.commit_add) begin
      mem[cmp_idx_q] <= {x_i, y_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        valid_q[i] <= 1'b0;
      end
      issuing_q   <= 1'b0;
      issue_q     <= '0;
      cmp_q       <= 1'b0;
      cmp_idx_q   <= '0;
      rd_vbit_q   <= 1'b0;
      free_mode_q <= 1'b0;
    end else begin
      if (req_i.commit_add) begin
        valid_q[cmp_idx_q] <= 1'b1;
      end
      if (req_i.commit_remove) begin
        valid_q[cmp_idx_q] <= 1'b0;
      end
      if (req_i.start) begin
        issuing_q   <= 1'b1;
        issue_q     <= '0;
        cmp_q       <= 1'b0;
        free_mode_q <= req_i.find_free;
      end else if (stop) begin
        issuing_q <= 1'b0;
        cmp_q     <= 1'b0;
      end else begin
        cmp_q <= issuing_q;
        if (issuing_q) begin
          cmp_idx_q <= issue_q;
          rd_vbit_q <= valid_q[issue_q];
          if (issue_q == IW'(MAX_POINTS - 1)) begin
            issuing_q <= 1'b0;
          end else begin
            issue_q <= issue_q + 1'b1;
          end
        end
      end
    end
  end

endmodule

### rtl/core/lslf_mul.sv
// Signed shift-add multiplier, one multiplier bit per cycle.
// Stand-alone; no package use.
`timescale 1ns / 1ps

module lslf_mul #(
  parameter int MAW = 52,
  parameter int MBW = 27
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [MAW-1:0]        a_i,
  input  logic signed [MBW-1:0]        b_i,
  output logic                         done_o,
  output logic signed [MAW+MBW-1:0]    p_o
);

  localparam int PW = MAW + MBW;
  localparam int CNW = $clog2(MBW);

  logic           busy_q;
  logic           fin_q;
  logic           done_q;
  logic           neg_q;
  logic [CNW-1:0] cnt_q;
  logic [PW-1:0]  a_sh_q;
  logic [MBW-1:0] b_sh_q;
  logic [PW-1:0]  acc_q;
  logic [PW-1:0]  p_q;

  logic [MAW-1:0] a_mag;
  logic [MBW-1:0] b_mag;

  assign a_mag  = a_i[MAW-1] ? MAW'(-a_i) : MAW'(a_i);
  assign b_mag  = b_i[MBW-1] ? MBW'(-b_i) : MBW'(b_i);
  assign done_o = done_q;
  assign p_o    = signed'(p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      a_sh_q <= '0;
      b_sh_q <= '0;
      acc_q  <= '0;
      p_q    <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        a_sh_q <= PW'(a_mag);
        b_sh_q <= b_mag;
        acc_q  <= '0;
        neg_q  <= a_i[MAW-1] ^ b_i[MBW-1];
      end else if (busy_q) begin
        if (b_sh_q[0]) begin
          acc_q <= acc_q + a_sh_q;
        end
        a_sh_q <= a_sh_q << 1;
        b_sh_q <= b_sh_q >> 1;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CNW'(MBW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        p_q    <= neg_q ? -acc_q : acc_q;
        done_q <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/lslf_div.sv
// Restoring divider, one quotient bit per cycle: |num| * 2^SH / |den|,
// truncated and saturated to 31 bits. Stand-alone; no package use.
`timescale 1ns / 1ps

module lslf_div #(
  parameter int NUMW = 80,
  parameter int DENW = 61,
  parameter int SH   = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic signed [DENW-1:0] den_i,
  output logic                   done_o,
  output logic [30:0]            q_o
);

  localparam int DVW = NUMW + SH;
  localparam int CNW = $clog2(DVW);

  logic            busy_q;
  logic            done_q;
  logic            ovf_q;
  logic [CNW-1:0]  cnt_q;
  logic [DVW-1:0]  dvd_q;
  logic [DENW-1:0] d_q;
  logic [DENW-1:0] rem_q;
  logic [31:0]     q_q;

  logic [NUMW-1:0] n_mag;
  logic [DENW-1:0] d_mag;
  logic [DENW:0]   r_sh;
  logic            ge;

  assign n_mag = num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
  assign d_mag = den_i[DENW-1] ? DENW'(-den_i) : DENW'(den_i);
  assign r_sh  = {rem_q, dvd_q[DVW-1]};
  assign ge    = r_sh >= {1'b0, d_q};

  assign done_o = done_q;
  assign q_o    = (ovf_q || q_q[31]) ? 31'h7FFF_FFFF : q_q[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      d_q    <= '0;
      rem_q  <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ovf_q  <= 1'b0;
        cnt_q  <= '0;
        dvd_q  <= {n_mag, SH'(0)};
        d_q    <= d_mag;
        rem_q  <= '0;
        q_q    <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? DENW'(r_sh - {1'b0, d_q}) : DENW'(r_sh);
        dvd_q <= dvd_q << 1;
        q_q   <= {q_q[30:0], ge};
        ovf_q <= ovf_q | q_q[31];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNW'(DVW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/least_squares_line_fit.sv
// Least-squares line fit over a bounded point store: top level and sequencer.
// Uses lslf_pkg, lslf_store, lslf_mul and lslf_div.
`timescale 1ns / 1ps

// One item at a time; the input is ready only while the sequencer idles, and
// a finished result waits in an output register while the next item is taken.
// Add, remove and find scan the point memory one slot per cycle, and add and
// remove then run two multiplies to update the x*y and x*x sums. A prediction
// runs up to eight multiplies on one shift-add multiplier (GW = 27 at 256
// points) and, unless it is degenerate, one restoring division.
// No clearing pass: slot valid bits reset at once.
module least_squares_line_fit #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // point_x[15:0], point_y[31:16], given_value[47:32]
  input  logic [2:0]  s_axis_tuser_i,  // kind[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // predicted[31:0]
  output logic [2:0]  m_axis_tuser_o   // status[2:0]
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SXW  = 16 + CW;
  localparam int SPW  = 32 + CW;
  localparam int NDW  = 2 * SXW + 2;
  localparam int GW   = SXW + 2;
  localparam int PW   = NDW + GW;
  localparam int NUMW = PW + 1;
  localparam int DENW = NDW + CW;
  localparam int SH   = 16 - FRAC_BITS;

  lslf_pkg::state_e  state_q, state_d;
  lslf_pkg::step_e   step_q, step_d;
  lslf_pkg::status_e res_status_q, res_status_d;
  logic [30:0]       res_pred_q, res_pred_d;

  logic [2:0]               kind_q;
  logic signed [15:0]       px_q, py_q, gv_q;
  logic [CW-1:0]            count_q, count_d;
  logic signed [SXW-1:0]    tx_q, tx_d, ty_q, ty_d;
  logic signed [SPW-1:0]    txy_q, txy_d, txx_q, txx_d;
  logic signed [NUMW-1:0]   t1_q, t1_d, num_q, num_d;
  logic signed [NDW-1:0]    nn_q, nn_d, dd_q, dd_d;
  logic signed [GW-1:0]     g_q, g_d;
  logic signed [DENW-1:0]   den_q, den_d;
  logic                     mul_go_q, mul_go_d, div_go_q, div_go_d, scan_go_q, scan_go_d;
  logic                     out_valid_q, out_valid_d;
  logic [2:0]               out_status_q;
  logic [31:0]              out_pred_q;

  logic                     accept;
  logic                     is_remove;
  logic                     pred_y;
  logic                     load_out;
  logic signed [NDW-1:0]    mul_a;
  logic signed [GW-1:0]     mul_b;
  logic                     mul_done, div_done;
  logic signed [PW-1:0]     mul_p;
  logic [30:0]              div_q;
  lslf_pkg::store_req_t     st_req;
  lslf_pkg::store_rsp_t     st_rsp;
  logic signed [GW-1:0]     n_op;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_remove = kind_q == lslf_pkg::K_REMOVE;
  assign pred_y    = kind_q == lslf_pkg::K_PRED_Y;
  assign n_op      = GW'(signed'({1'b0, count_q}));
  assign load_out  = state_q == lslf_pkg::S_RESP && (!out_valid_q || m_axis_tready_i);

  lslf_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .x_i    (px_q),
    .y_i    (py_q),
    .rsp_o  (st_rsp)
  );

  lslf_mul #(.MAW(NDW), .MBW(GW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  lslf_div #(.NUMW(NUMW), .DENW(DENW), .SH(SH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Outputs and operand select
  always_comb begin
    s_axis_tready_o = state_q == lslf_pkg::S_IDLE;
    st_req.start         = scan_go_q;
    st_req.find_free     = kind_q == lslf_pkg::K_ADD;
    st_req.commit_add    = state_q == lslf_pkg::S_SCAN && st_rsp.hit
                           && kind_q == lslf_pkg::K_ADD;
    st_req.commit_remove = state_q == lslf_pkg::S_SCAN && st_rsp.hit && is_remove;
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      lslf_pkg::M_XY:   begin mul_a = NDW'(px_q);  mul_b = GW'(py_q);  end
      lslf_pkg::M_XX:   begin mul_a = NDW'(px_q);  mul_b = GW'(px_q);  end
      lslf_pkg::M_NTXY: begin mul_a = NDW'(txy_q); mul_b = n_op;       end
      lslf_pkg::M_TXTY: begin mul_a = NDW'(tx_q);  mul_b = GW'(ty_q);  end
      lslf_pkg::M_NTXX: begin mul_a = NDW'(txx_q); mul_b = n_op;       end
      lslf_pkg::M_TXTX: begin mul_a = NDW'(tx_q);  mul_b = GW'(tx_q);  end
      lslf_pkg::M_NG:   begin mul_a = NDW'(gv_q);  mul_b = n_op;       end
      lslf_pkg::M_P5:   begin mul_a = dd_q; mul_b = pred_y ? GW'(ty_q) : g_q; end
      lslf_pkg::M_P6:   begin mul_a = nn_q; mul_b = pred_y ? g_q : GW'(tx_q); end
      lslf_pkg::M_P7:   begin mul_a = pred_y ? dd_q : nn_q; mul_b = n_op;      end
      default:          begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Next state and datapath
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    res_status_d = res_status_q;
    res_pred_d   = res_pred_q;
    count_d      = count_q;
    tx_d         = tx_q;
    ty_d         = ty_q;
    txy_d        = txy_q;
    txx_d        = txx_q;
    t1_d         = t1_q;
    nn_d         = nn_q;
    dd_d         = dd_q;
    g_d          = g_q;
    num_d        = num_q;
    den_d        = den_q;
    mul_go_d     = 1'b0;
    div_go_d     = 1'b0;
    scan_go_d    = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      lslf_pkg::S_IDLE: begin
        if (accept) begin
          res_pred_d = '0;
          priority if (s_axis_tuser_i == lslf_pkg::K_ADD && count_q >= CW'(MAX_POINTS)) begin
            res_status_d = lslf_pkg::ST_FULL;
            state_d      = lslf_pkg::S_RESP;
          end else if (s_axis_tuser_i == lslf_pkg::K_ADD
                       || s_axis_tuser_i == lslf_pkg::K_REMOVE
                       || s_axis_tuser_i == lslf_pkg::K_FIND) begin
            scan_go_d = 1'b1;
            state_d   = lslf_pkg::S_SCAN;
          end else if (s_axis_tuser_i == lslf_pkg::K_PRED_X
                       || s_axis_tuser_i == lslf_pkg::K_PRED_Y) begin
            step_d   = lslf_pkg::M_NTXY;
            mul_go_d = 1'b1;
            state_d  = lslf_pkg::S_MUL;
          end else begin
            res_status_d = lslf_pkg::ST_DEGENERATE;
            state_d      = lslf_pkg::S_RESP;
          end
        end
      end
      lslf_pkg::S_SCAN: begin
        if (st_rsp.done) begin
          priority if (!st_rsp.hit) begin
            res_status_d = (kind_q == lslf_pkg::K_ADD) ? lslf_pkg::ST_FULL
                                                       : lslf_pkg::ST_NOT_FOUND;
            state_d = lslf_pkg::S_RESP;
          end else if (kind_q == lslf_pkg::K_FIND) begin
            res_status_d = lslf_pkg::ST_FOUND;
            state_d      = lslf_pkg::S_RESP;
          end else begin
            res_status_d = is_remove ? lslf_pkg::ST_REMOVED : lslf_pkg::ST_ADDED;
            step_d       = lslf_pkg::M_XY;
            mul_go_d     = 1'b1;
            state_d      = lslf_pkg::S_MUL;
          end
        end
      end
      lslf_pkg::S_MUL: begin
        if (mul_done) begin
          mul_go_d = 1'b1;
          unique case (step_q)
            lslf_pkg::M_XY: begin
              txy_d  = is_remove ? txy_q - SPW'(mul_p) : txy_q + SPW'(mul_p);
              step_d = lslf_pkg::M_XX;
            end
            lslf_pkg::M_XX: begin
              txx_d    = is_remove ? txx_q - SPW'(mul_p) : txx_q + SPW'(mul_p);
              tx_d     = is_remove ? tx_q - SXW'(px_q) : tx_q + SXW'(px_q);
              ty_d     = is_remove ? ty_q - SXW'(py_q) : ty_q + SXW'(py_q);
              count_d  = is_remove ? count_q - 1'b1 : count_q + 1'b1;
              mul_go_d = 1'b0;
              state_d  = lslf_pkg::S_RESP;
            end
            lslf_pkg::M_NTXY: begin
              t1_d   = NUMW'(mul_p);
              step_d = lslf_pkg::M_TXTY;
            end
            lslf_pkg::M_TXTY: begin
              nn_d   = NDW'(t1_q) - NDW'(mul_p);
              step_d = lslf_pkg::M_NTXX;
            end
            lslf_pkg::M_NTXX: begin
              t1_d   = NUMW'(mul_p);
              step_d = lslf_pkg::M_TXTX;
            end
            lslf_pkg::M_TXTX: begin
              dd_d = NDW'(t1_q) - NDW'(mul_p);
              if (count_q < CW'(2) || dd_d == '0 || (!pred_y && nn_q == '0)) begin
                res_status_d = lslf_pkg::ST_DEGENERATE;
                mul_go_d     = 1'b0;
                state_d      = lslf_pkg::S_RESP;
              end else begin
                step_d = lslf_pkg::M_NG;
              end
            end
            lslf_pkg::M_NG: begin
              g_d    = GW'(mul_p) - GW'(pred_y ? tx_q : ty_q);
              step_d = lslf_pkg::M_P5;
            end
            lslf_pkg::M_P5: begin
              t1_d   = NUMW'(mul_p);
              step_d = lslf_pkg::M_P6;
            end
            lslf_pkg::M_P6: begin
              num_d  = t1_q + NUMW'(mul_p);
              step_d = lslf_pkg::M_P7;
            end
            lslf_pkg::M_P7: begin
              den_d    = DENW'(mul_p);
              mul_go_d = 1'b0;
              div_go_d = 1'b1;
              state_d  = lslf_pkg::S_DIV;
            end
            default: begin
              mul_go_d = 1'b0;
              state_d  = lslf_pkg::S_IDLE;
            end
          endcase
        end
      end
      lslf_pkg::S_DIV: begin
        if (div_done) begin
          res_pred_d   = div_q;
          res_status_d = lslf_pkg::ST_PREDICTED;
          state_d      = lslf_pkg::S_RESP;
        end
      end
      lslf_pkg::S_RESP: begin
        if (load_out) begin
          state_d = lslf_pkg::S_IDLE;
        end
      end
      default: state_d = lslf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lslf_pkg::S_IDLE;
      step_q       <= lslf_pkg::M_XY;
      res_status_q <= lslf_pkg::ST_DEGENERATE;
      count_q      <= '0;
      tx_q         <= '0;
      ty_q         <= '0;
      txy_q        <= '0;
      txx_q        <= '0;
      mul_go_q     <= 1'b0;
      div_go_q     <= 1'b0;
      scan_go_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      res_status_q <= res_status_d;
      count_q      <= count_d;
      tx_q         <= tx_d;
      ty_q         <= ty_d;
      txy_q        <= txy_d;
      txx_q        <= txx_d;
      mul_go_q     <= mul_go_d;
      div_go_q     <= div_go_d;
      scan_go_q    <= scan_go_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser_i;
      px_q   <= s_axis_tdata_i[15:0];
      py_q   <= s_axis_tdata_i[31:16];
      gv_q   <= s_axis_tdata_i[47:32];
    end
    res_pred_q <= res_pred_d;
    t1_q       <= t1_d;
    nn_q       <= nn_d;
    dd_q       <= dd_d;
    g_q        <= g_d;
    num_q      <= num_d;
    den_q      <= den_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_pred_q   <= {1'b0, res_pred_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pred_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

### rtl/core/lslf_checker.sv
// Port-level checks for the line-fit block, bound to the top level.
// Uses lslf_pkg and least_squares_line_fit_macros.svh.
`timescale 1ns / 1ps
`include "least_squares_line_fit_macros.svh"

module lslf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] s_axis_tdata_i,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // a stalled result stays offered
  `LSLF_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")

  // only a prediction carries a value
  `LSLF_ASSERT(a_pred_zero, m_axis_tvalid_o && m_axis_tuser_o != lslf_pkg::ST_PREDICTED |-> m_axis_tdata_o == 32'd0, "nonzero value without prediction")

  // magnitude is saturated to 31 bits
  `LSLF_ASSERT(a_pred_sign, m_axis_tvalid_o |-> !m_axis_tdata_o[31], "negative predicted value")

  // one item at a time: busy right after a transfer in
  `LSLF_ASSERT_ALWAYS(a_busy, rst_ni && s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o || !rst_ni, "input taken while busy")

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);
